@@ rtl/first_fit_arena_allocator_defines.svh @@
// Assertion macros shared by the allocator checker.
// Needs a clk and rst in the scope where a macro is used.
`ifndef FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define FFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, off during reset.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication that also holds through reset.
`define FFA_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/ffa_pkg.sv @@
// Package for the first-fit arena allocator: constants, codes, table entry
// and shared-unit types. Used by ffa_alu, the allocator and its checker.
`default_nettype none
package ffa_pkg;

  localparam int ARENA_BYTES     = 32768;
  localparam int ALIGN_BYTES     = 16;
  localparam int HEADER_BYTES    = 24;
  localparam int CHUNK_SLOTS_DEF = 2048;
  localparam int OFFSET_MAX      = 32767;
  localparam int LIMIT_RESET     = 32768;
  localparam int AW              = 18;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_OOM    = 2'd1,
    ST_BADPTR = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_BUMP, S_BUMP2, S_PRV_RD, S_PRV_CHK,
    S_NXT_RD, S_NXT_CHK, S_MRG_WR, S_SH_RD, S_SH_WR, S_DONE
  } fsm_t;

  typedef struct packed {
    logic        is_free;
    logic [15:0] size;
    logic [14:0] start;
  } entry_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [AW-1:0] b;
    logic [AW-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [AW-1:0] sum;
    logic          ge;
    logic          eq;
  } alu_rsp_t;

  function automatic logic [AW-1:0] align_down(input logic [AW-1:0] x);
    return x & ~AW'(ALIGN_BYTES - 1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/ffa_ifs.sv @@
// Channel interfaces of the allocator: request, result and limit write.
// Depends on nothing.
`default_nettype none
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] request_bytes;
  logic [14:0] release_offset;
  modport source (output valid, operation, request_bytes, release_offset, input ready);
  modport sink (input valid, operation, request_bytes, release_offset, output ready);
endinterface

interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [14:0] payload_offset;
  logic [1:0]  status;
  logic [11:0] live_count;
  modport source (output valid, payload_offset, status, live_count, input ready);
  modport sink (input valid, payload_offset, status, live_count, output ready);
endinterface

interface ffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] arena_limit;
  modport source (output valid, arena_limit, input ready);
  modport sink (input valid, arena_limit, output ready);
endinterface
`default_nettype wire

@@ rtl/ffa_alu.sv @@
// Add and compare unit shared by the idle, check, bump and neighbour steps.
// Depends on ffa_pkg.
`default_nettype none
module ffa_alu (
  input  ffa_pkg::alu_req_t op_in,
  output ffa_pkg::alu_rsp_t res
);
  import ffa_pkg::*;

  logic [AW-1:0] sum;

  assign sum     = op_in.a + op_in.b;
  assign res.sum = sum;
  assign res.ge  = op_in.a >= op_in.b;
  assign res.eq  = sum == op_in.c;
endmodule
`default_nettype wire

@@ rtl/first_fit_arena_allocator.sv @@
// Channel | dir | word
// req     | in  | operation, request_bytes, release_offset
// rsp     | out | payload_offset, status, live_count
// cfg     | in  | arena_limit, always ready
// An allocate walks the chunks to the first free one that fits, else bumps a
// new chunk; a free walks to the match, checks its neighbours, writes the
// merge and moves later entries down after a merge. The table walk reads one
// entry at a time. Reset (rst, synchronous) empties the arena at once; the
// table holds no clear. A stalled result holds in the output word; the next
// request runs and waits in its done step until that word is taken.
`default_nettype none
module first_fit_arena_allocator #(
  parameter int CHUNK_SLOTS = ffa_pkg::CHUNK_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ffa_req_if.sink   req,
  ffa_rsp_if.source rsp,
  ffa_cfg_if.sink   cfg
);
  import ffa_pkg::*;

  localparam int IW = $clog2(CHUNK_SLOTS);
  localparam int CW = IW + 1;

  fsm_t state, state_next;

  entry_t mem [CHUNK_SLOTS];
  entry_t rdata, wdata;
  logic   we;
  logic [IW-1:0] waddr;

  logic          op;
  logic [AW-1:0] need, fp, lim, bump, msz;
  logic [14:0]   rel, ks, ps;
  logic [CW-1:0] ptr, k, wj, total, live;
  logic [1:0]    d;
  logic [1:0]    mrg;
  logic          pf, nf;
  logic [15:0]   limit;
  logic [14:0]   res_off;
  status_t       res_st;

  alu_req_t alu_in;
  alu_rsp_t alu_out;

  logic last, alloc_hit, bump_fail, has_next;
  logic [CW-1:0] j_first;

  ffa_alu u_alu (.op_in(alu_in), .res(alu_out));

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);

  assign last      = (ptr + CW'(1)) == total;
  assign has_next  = (k + CW'(1)) < total;
  assign alloc_hit = rdata.is_free && alu_out.ge;
  assign bump_fail = (bump > lim) || (alu_out.sum > lim) ||
                     (bump > AW'(OFFSET_MAX - HEADER_BYTES));
  assign j_first   = pf ? k : k + CW'(1);
  // Entries absorbed by the merge being written.
  assign mrg       = 2'(pf) + 2'(nf);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operand selection, table writes and next state.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = ptr[IW-1:0];
    wdata      = rdata;
    alu_in     = '0;
    case (state)
      S_IDLE: begin
        alu_in.a = AW'(req.request_bytes);
        alu_in.b = AW'(ALIGN_BYTES - 1);
        if (req.valid) begin
          if (total == '0) begin
            state_next = req.operation ? S_DONE : S_BUMP;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: state_next = S_CHK;
      S_CHK: begin
        if (!op) begin
          alu_in.a = AW'(rdata.size);
          alu_in.b = need;
          if (alloc_hit) begin
            we            = 1'b1;
            wdata.is_free = 1'b0;
            state_next    = S_DONE;
          end else begin
            state_next = last ? S_BUMP : S_RD;
          end
        end else begin
          alu_in.a = AW'(rdata.start);
          alu_in.b = AW'(HEADER_BYTES);
          alu_in.c = AW'(rel);
          if (alu_out.eq) begin
            if (rdata.is_free) begin
              state_next = S_DONE;
            end else if (ptr != '0) begin
              state_next = S_PRV_RD;
            end else if (!last) begin
              state_next = S_NXT_RD;
            end else begin
              state_next = S_MRG_WR;
            end
          end else begin
            state_next = last ? S_DONE : S_RD;
          end
        end
      end
      S_BUMP: begin
        alu_in.a = need;
        alu_in.b = AW'(HEADER_BYTES + ALIGN_BYTES - 1);
        state_next = (total == CW'(CHUNK_SLOTS)) ? S_DONE : S_BUMP2;
      end
      S_BUMP2: begin
        alu_in.a = bump;
        alu_in.b = fp;
        if (!bump_fail) begin
          we    = 1'b1;
          waddr = total[IW-1:0];
          wdata = '{is_free: 1'b0, size: need[15:0], start: bump[14:0]};
        end
        state_next = S_DONE;
      end
      S_PRV_RD: state_next = S_PRV_CHK;
      S_PRV_CHK: begin
        alu_in.a   = msz;
        alu_in.b   = AW'(rdata.size) + AW'(HEADER_BYTES);
        state_next = has_next ? S_NXT_RD : S_MRG_WR;
      end
      S_NXT_RD: state_next = S_NXT_CHK;
      S_NXT_CHK: begin
        alu_in.a   = msz;
        alu_in.b   = AW'(rdata.size) + AW'(HEADER_BYTES);
        state_next = S_MRG_WR;
      end
      S_MRG_WR: begin
        we    = 1'b1;
        waddr = pf ? IW'(k - CW'(1)) : k[IW-1:0];
        wdata = '{is_free: 1'b1, size: msz[15:0], start: (pf ? ps : ks)};
        if (mrg != '0 && (j_first + CW'(mrg)) < total) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SH_RD: state_next = S_SH_WR;
      S_SH_WR: begin
        we         = 1'b1;
        waddr      = wj[IW-1:0];
        state_next = ((ptr + CW'(1)) < total) ? S_SH_RD : S_DONE;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      bump  <= '0;
      live  <= '0;
      limit <= 16'(LIMIT_RESET);
    end else begin
      if (cfg.valid) begin
        limit <= cfg.arena_limit;
      end
      case (state)
        S_IDLE: begin
          op      <= req.operation;
          rel     <= req.release_offset;
          need    <= align_down(alu_out.sum);
          ptr     <= '0;
          res_off <= '0;
          res_st  <= req.operation ? ST_BADPTR : ST_OK;
        end
        S_CHK: begin
          if (!op) begin
            if (alloc_hit) begin
              live    <= live + CW'(1);
              res_off <= 15'(AW'(rdata.start) + AW'(HEADER_BYTES));
              res_st  <= ST_OK;
            end else if (!last) begin
              ptr <= ptr + CW'(1);
            end
          end else if (alu_out.eq) begin
            if (rdata.is_free) begin
              res_st <= ST_DOUBLE;
            end else begin
              res_st <= ST_OK;
              k      <= ptr;
              ks     <= rdata.start;
              msz    <= AW'(rdata.size);
              pf     <= 1'b0;
              nf     <= 1'b0;
              if (live != '0) begin
                live <= live - CW'(1);
              end
              if (ptr != '0) begin
                ptr <= ptr - CW'(1);
              end else if (!last) begin
                ptr <= ptr + CW'(1);
              end
            end
          end else if (!last) begin
            ptr <= ptr + CW'(1);
          end
        end
        S_BUMP: begin
          fp     <= align_down(alu_out.sum);
          lim    <= (limit > 16'(ARENA_BYTES)) ? AW'(ARENA_BYTES) : AW'(limit);
          res_st <= ST_OOM;
        end
        S_BUMP2: begin
          if (!bump_fail) begin
            total   <= total + CW'(1);
            live    <= live + CW'(1);
            bump    <= alu_out.sum;
            res_off <= 15'(bump + AW'(HEADER_BYTES));
            res_st  <= ST_OK;
          end
        end
        S_PRV_CHK: begin
          if (rdata.is_free) begin
            pf  <= 1'b1;
            ps  <= rdata.start;
            msz <= alu_out.sum;
          end
          if (has_next) begin
            ptr <= k + CW'(1);
          end
        end
        S_NXT_CHK: begin
          if (rdata.is_free) begin
            nf  <= 1'b1;
            msz <= alu_out.sum;
          end
        end
        S_MRG_WR: begin
          d   <= mrg;
          wj  <= j_first;
          ptr <= j_first + CW'(mrg);
          if ((j_first + CW'(mrg)) >= total) begin
            total <= total - CW'(mrg);
          end
        end
        S_SH_WR: begin
          wj  <= wj + CW'(1);
          ptr <= ptr + CW'(1);
          if ((ptr + CW'(1)) >= total) begin
            total <= total - CW'(d);
          end
        end
        default: ;
      endcase
    end
  end

  // Output word: load on leaving the done step, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.payload_offset <= res_off;
      rsp.status         <= res_st;
      rsp.live_count     <= 12'(live);
    end
  end
endmodule
`default_nettype wire

@@ rtl/ffa_chk.sv @@
// Port-level checker for the allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_arena_allocator_defines.svh.
`default_nettype none
module ffa_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [14:0] payload_offset,
  input wire logic [1:0]  status
);
  import ffa_pkg::*;
  `include "first_fit_arena_allocator_defines.svh"

  // The allocator is busy in the cycle after it accepts a request.
  `FFA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
  // A failed request never grants an offset.
  `FFA_ASSERT_NOW(a_fail_no_offset, rsp_valid && status != ST_OK, payload_offset == '0)
  // A stalled result holds.
  `FFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(payload_offset) && $stable(status))
  // Reset empties the output word.
  `FFA_ASSERT_ALWAYS(a_reset_clear, rst, !rsp_valid)
endmodule

bind first_fit_arena_allocator ffa_chk u_ffa_chk (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .payload_offset(rsp.payload_offset),
  .status(rsp.status)
);
`default_nettype wire
